// ----- rtl/e2c_pkg.sv -----
// Package for the epoch to calendar unit: shared widths, types and helpers.
// No dependencies.
package e2c_pkg;

    localparam int EPOCH_W = 32;
    localparam int DAYS_W  = 16;
    localparam logic [8:0] YEAR_DAYS = 9'd365;

    // Result fields of one item.
    typedef struct packed {
        logic              valid_res;
        logic [4:0]        mday;
        logic [3:0]        month;
        logic [8:0]        yday;
        logic signed [7:0] year_from_2000;
        logic [2:0]        weekday;
        logic [15:0]       days_since_epoch;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } cal_res_t;

    // Gregorian leap rule for a year counted from 1970 (only 2100 is a non-leap century in range).
    function automatic logic leap_at(input logic [7:0] yoff);
        logic [7:0] y;
        y = yoff + 8'd2;
        leap_at = (y[1:0] == 2'b00) && (yoff != 8'd130);
    endfunction

    // Cumulative day count before each month, one more from March on in a leap year; month index 0..11.
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        unique case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd511;
        endcase
        if (leap && (m >= 4'd2) && (m <= 4'd11))
        begin
            s = s + 9'd1;
        end
        month_start = s;
    endfunction

    // Weekday from the day count, 1 is Sunday; 1970-01-01 was a Thursday.
    // The remainder by seven uses a reciprocal that can be one high and is corrected.
    function automatic logic [2:0] weekday_of(input logic [15:0] d);
        logic [16:0] x;
        logic [30:0] p;
        logic [13:0] q;
        logic [16:0] q7;
        x  = {1'b0, d} + 17'd4;
        p  = {14'd0, x} * 31'd9363;            // ceil(2^16/7)
        q  = p[29:16];
        q7 = {q, 3'd0} - {3'd0, q};
        if (q7 > x)
        begin
            q7 = q7 - 17'd7;
        end
        weekday_of = 3'(x - q7) + 3'd1;
    endfunction

endpackage

// ----- rtl/e2c_time_split.sv -----
// Time split stages: seconds, minutes, hours and day count.
// Depends on e2c_pkg.
module e2c_time_split (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [31:0]               epoch,
    input  logic                      above_min,
    output logic                      out_vld,
    output logic [15:0]               days,
    output logic [5:0]                sec,
    output logic [5:0]                min,
    output logic [4:0]                hr,
    output logic                      ok
);
    import e2c_pkg::*;

    // Stage registers.
    logic        v1_reg, v2_reg, v3_reg;
    logic [26:0] q1_reg;
    logic [20:0] q2_reg;
    logic [5:0]  s1_reg, s2_reg, s3_reg, m2_reg, m3_reg;
    logic [4:0]  h3_reg;
    logic [15:0] d3_reg;
    logic        ok1_reg, ok2_reg, ok3_reg;

    logic [26:0] q1_next;
    logic [20:0] q2_next;
    logic [15:0] d3_next;
    logic [58:0] p1;
    logic [48:0] p2;
    logic [36:0] p3;
    logic [33:0] q1x60;
    logic [27:0] q2x60;
    logic [20:0] d3x24;

    // Division by constants through reciprocal multiplication; a quotient that is
    // one too high is corrected by comparing its product with the dividend.
    always_comb
    begin
        p1      = {27'd0, epoch} * 59'd71582789;   // ceil(2^32/60)
        q1_next = p1[58:32];
        q1x60   = {1'b0, q1_next, 6'd0} - {5'd0, q1_next, 2'd0};
        if (q1x60 > {2'd0, epoch})
        begin
            q1_next = q1_next - 27'd1;
            q1x60   = q1x60 - 34'd60;
        end
        p2      = {22'd0, q1_reg} * 49'd2236963;    // ceil(2^27/60)
        q2_next = p2[47:27];
        q2x60   = {1'b0, q2_next, 6'd0} - {5'd0, q2_next, 2'd0};
        if (q2x60 > {1'b0, q1_reg})
        begin
            q2_next = q2_next - 21'd1;
            q2x60   = q2x60 - 28'd60;
        end
        p3      = {16'd0, q2_reg} * 37'd43691;      // ceil(2^20/24)
        d3_next = p3[35:20];
        d3x24   = {1'b0, d3_next, 4'd0} + {2'd0, d3_next, 3'd0};
        if (d3x24 > q2_reg)
        begin
            d3_next = d3_next - 16'd1;
            d3x24   = d3x24 - 21'd24;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg  <= q1_next;
            s1_reg  <= 6'(epoch - q1x60[31:0]);
            ok1_reg <= above_min;
            q2_reg  <= q2_next;
            m2_reg  <= 6'(q1_reg - q2x60[26:0]);
            s2_reg  <= s1_reg;
            ok2_reg <= ok1_reg;
            d3_reg  <= d3_next;
            h3_reg  <= 5'(q2_reg - d3x24);
            m3_reg  <= m2_reg;
            s3_reg  <= s2_reg;
            ok3_reg <= ok2_reg;
        end
    end

    assign out_vld = v3_reg;
    assign days    = d3_reg;
    assign sec     = s3_reg;
    assign min     = m3_reg;
    assign hr      = h3_reg;
    assign ok      = ok3_reg;
endmodule

// ----- rtl/e2c_date_split.sv -----
// Date stages: year from the day count, then month and day of month.
// Depends on e2c_pkg.
module e2c_date_split (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [15:0] days,
    output logic        out_vld,
    output logic [7:0]  yoff,
    output logic [8:0]  doy,
    output logic [3:0]  month,
    output logic [4:0]  dom
);
    import e2c_pkg::*;

    // Stage A: year estimate days*4/1461 rounded down; Stage B: correct; Stage C: month.
    logic        va_reg, vb_reg, vc_reg;
    logic [15:0] da_reg;
    logic [7:0]  ya_reg, yb_reg, yc_reg;
    logic [8:0]  db_reg, dc_reg;
    logic [3:0]  mc_reg;
    logic [4:0]  domc_reg;

    logic [33:0] pa;
    logic [7:0]  ya_next;
    logic [16:0] ystart;
    logic [16:0] yrem;
    logic [7:0]  yb_next;
    logic [8:0]  db_next;
    logic        lp;
    logic [3:0]  mc_next;
    logic [8:0]  ms;
    logic [8:0]  mnext;

    always_comb
    begin
        // days*4/1461 via reciprocal, within one year of the true year.
        pa      = {18'd0, days} * 34'd11484;       // ceil(2^22*4/1461)
        ya_next = 8'(pa[33:22]);
        // Days before year ya_reg from 1970, with 2100 not leap.
        ystart  = 17'(({9'd0, ya_reg} * 17'd365) + ((17'(ya_reg) + 17'd1) >> 2));
        if (ya_reg > 8'd130)
        begin
            ystart = ystart - 17'd1;
        end
        yb_next = ya_reg;
        yrem    = {1'b0, da_reg} - ystart;
        if (ystart > {1'b0, da_reg})
        begin
            yb_next = ya_reg - 8'd1;
            yrem    = yrem + (leap_at(yb_next) ? 17'd366 : 17'd365);
        end
        else if (yrem >= (leap_at(ya_reg) ? 17'd366 : 17'd365))
        begin
            yrem    = yrem - (leap_at(ya_reg) ? 17'd366 : 17'd365);
            yb_next = ya_reg + 8'd1;
        end
        db_next = yrem[8:0];
        // Month: last month whose start is at or below the day.
        lp      = leap_at(yb_reg);
        mc_next = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (month_start(4'(i), lp) <= db_reg)
            begin
                mc_next = 4'(i);
            end
        end
        ms    = month_start(mc_next, lp);
        mnext = db_reg - ms + 9'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_vld;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da_reg   <= days;
            ya_reg   <= ya_next;
            yb_reg   <= yb_next;
            db_reg   <= db_next;
            yc_reg   <= yb_reg;
            dc_reg   <= db_reg;
            mc_reg   <= mc_next + 4'd1;
            domc_reg <= mnext[4:0];
        end
    end

    assign out_vld = vc_reg;
    assign yoff    = yc_reg;
    assign doy     = dc_reg;
    assign month   = mc_reg;
    assign dom     = domc_reg;
endmodule

// ----- rtl/epoch_to_calendar_unit.sv -----
// Epoch to calendar conversion, fully pipelined.
// Seven register stages lie between an accepted item and its result.
// Throughput one item per cycle while the output register is free or draining: every stage
// advances then, and the whole pipeline stalls otherwise.
// Reset clears all valid bits and sets min_epoch_reg to zero.
// Depends on e2c_pkg, e2c_time_split and e2c_date_split.
module epoch_to_calendar_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // second, minute, hour, days_since_epoch,
                                        // weekday, year_from_2000, year day,
                                        // month, month day, valid_res; zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import e2c_pkg::*;

    logic [31:0] min_epoch_reg;
    logic        en;
    logic        tv, ok, dv;
    logic [15:0] days;
    logic [5:0]  sec, min;
    logic [4:0]  hr;
    logic [7:0]  yoff;
    logic [8:0]  doy;
    logic [3:0]  mon;
    logic [4:0]  dom;
    logic        out_v_reg;
    cal_res_t    res_reg;
    logic [2:0]  dw_d1_reg, dw_d2_reg, dw_d3_reg;
    logic [15:0] dd1_reg, dd2_reg, dd3_reg;
    logic [16:0] tm1_reg, tm2_reg, tm3_reg;
    logic        ok1_reg, ok2_reg, ok3_reg;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? min_epoch_reg : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_epoch_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && (paddr == 3'd0))
        begin
            min_epoch_reg <= pwdata;
        end
    end

    // The whole pipeline advances while the output register is free or draining.
    assign en            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    e2c_time_split u_time (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s_axis_tvalid && en),
        .epoch(s_axis_tdata), .above_min(s_axis_tdata > min_epoch_reg),
        .out_vld(tv), .days(days), .sec(sec), .min(min), .hr(hr), .ok(ok)
    );

    e2c_date_split u_date (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(tv), .days(days),
        .out_vld(dv), .yoff(yoff), .doy(doy), .month(mon), .dom(dom)
    );

    // Delay the time fields alongside the date stages; the weekday is worked out
    // from the registered day count in the first of these stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm1_reg   <= {hr, min, sec};
            tm2_reg   <= tm1_reg;
            tm3_reg   <= tm2_reg;
            dd1_reg   <= days;
            dd2_reg   <= dd1_reg;
            dd3_reg   <= dd2_reg;
            dw_d1_reg <= weekday_of(days);
            dw_d2_reg <= dw_d1_reg;
            dw_d3_reg <= dw_d2_reg;
            ok1_reg   <= ok;
            ok2_reg   <= ok1_reg;
            ok3_reg   <= ok2_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.second           <= tm3_reg[5:0];
            res_reg.minute           <= tm3_reg[11:6];
            res_reg.hour             <= tm3_reg[16:12];
            res_reg.days_since_epoch <= dd3_reg;
            res_reg.weekday          <= dw_d3_reg;
            res_reg.year_from_2000   <= signed'(yoff - 8'd30);
            res_reg.yday             <= doy;
            res_reg.month            <= mon;
            res_reg.mday             <= dom;
            res_reg.valid_res        <= ok3_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {1'b0, res_reg};
endmodule
